>>> rtl/usbsr_pkg.sv
// Shared types, codes and constants of the USB standard request responder.
package usbsr_pkg;

    localparam int unsigned TdataInW  = 72;
    localparam int unsigned TuserInW  = 3;
    localparam int unsigned TdataOutW = 16;
    localparam int unsigned TuserOutW = 2;
    localparam int unsigned CfgAddrW  = 3;
    localparam int unsigned CfgDataW  = 8;

    typedef enum logic [2:0] {
        MODE_SETUP     = 3'd0,
        MODE_BUS_RESET = 3'd1,
        MODE_SUSPEND   = 3'd2,
        MODE_RESUME    = 3'd3,
        MODE_EP0_DONE  = 3'd4,
        MODE_POWER_OFF = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_ACK   = 2'd1,
        ACT_STALL = 2'd2,
        ACT_SEND  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        XFER_OK      = 2'd0,
        XFER_ABORTED = 2'd1,
        XFER_FAILED  = 2'd2
    } t_xfer_status;

    typedef enum logic [CfgAddrW-1:0] {
        CFG_RWU_SUPPORTED = 3'd0,
        CFG_DEVICE_LEN    = 3'd1,
        CFG_CONFIG_LEN    = 3'd2,
        CFG_LANG_LEN      = 3'd3,
        CFG_MANUF_LEN     = 3'd4,
        CFG_PRODUCT_LEN   = 3'd5,
        CFG_IFACE_LEN     = 3'd6,
        CFG_EP_LEN        = 3'd7
    } t_cfg_index;

    // Standard request codes.
    localparam logic [7:0] REQ_GET_STATUS     = 8'd0;
    localparam logic [7:0] REQ_CLEAR_FEATURE  = 8'd1;
    localparam logic [7:0] REQ_SET_FEATURE    = 8'd3;
    localparam logic [7:0] REQ_SET_ADDRESS    = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;
    localparam logic [7:0] REQ_GET_CONFIG     = 8'd8;
    localparam logic [7:0] REQ_SET_CONFIG     = 8'd9;

    // Request types.
    localparam logic [7:0] RT_OUT_DEVICE   = 8'h00;
    localparam logic [7:0] RT_OUT_ENDPOINT = 8'h02;
    localparam logic [7:0] RT_IN_DEVICE    = 8'h80;
    localparam logic [7:0] RT_IN_IFACE     = 8'h81;
    localparam logic [7:0] RT_IN_ENDPOINT  = 8'h82;

    // Descriptor types.
    localparam logic [7:0] DESC_DEVICE   = 8'd1;
    localparam logic [7:0] DESC_CONFIG   = 8'd2;
    localparam logic [7:0] DESC_STRING   = 8'd3;
    localparam logic [7:0] DESC_IFACE    = 8'd4;
    localparam logic [7:0] DESC_ENDPOINT = 8'd5;

    localparam logic [7:0]  EP_IN1          = 8'h81;
    localparam logic [15:0] FEAT_EP_HALT    = 16'd0;
    localparam logic [15:0] FEAT_REMOTE_WU  = 16'd1;
    localparam logic [15:0] CONFIG_NONE     = 16'd0;
    localparam logic [15:0] CONFIG_ONE      = 16'd1;

    // Response selections.
    localparam logic [3:0] SEL_DEV_STATUS    = 4'd0;
    localparam logic [3:0] SEL_DEV_STATUS_WU = 4'd1;
    localparam logic [3:0] SEL_IFACE_STATUS  = 4'd2;
    localparam logic [3:0] SEL_EP_ACTIVE     = 4'd3;
    localparam logic [3:0] SEL_EP_HALTED     = 4'd4;
    localparam logic [3:0] SEL_DEVICE_DESC   = 4'd5;
    localparam logic [3:0] SEL_CONFIG_DESC   = 4'd6;
    localparam logic [3:0] SEL_LANG_STRING   = 4'd7;
    localparam logic [3:0] SEL_MANUF_STRING  = 4'd8;
    localparam logic [3:0] SEL_PROD_STRING   = 4'd9;
    localparam logic [3:0] SEL_IFACE_DESC    = 4'd10;
    localparam logic [3:0] SEL_EP_DESC       = 4'd11;
    localparam logic [3:0] SEL_CONFIG_UNCONF = 4'd12;
    localparam logic [3:0] SEL_CONFIG_CONF   = 4'd13;

    localparam logic [7:0] STATUS_SIZE = 8'd2;
    localparam logic [7:0] CONFIG_SIZE = 8'd1;

    typedef struct packed {
        logic [1:0]  transfer_status;
        logic [15:0] req_length;
        logic [15:0] req_index;
        logic [15:0] req_value;
        logic [7:0]  request_code;
        logic [7:0]  request_type;
    } t_setup;

    typedef struct packed {
        logic configured;
        logic wakeup_on;
        logic ep_halted;
        logic suspend;
    } t_flags;

    typedef struct packed {
        logic       rwu_supported;
        logic [7:0] device_len;
        logic [7:0] config_len;
        logic [7:0] lang_len;
        logic [7:0] manuf_len;
        logic [7:0] product_len;
        logic [7:0] iface_len;
        logic [7:0] ep_len;
    } t_cfg;

    typedef struct packed {
        t_action    action;
        logic [3:0] response_select;
        logic [7:0] send_length;
        t_flags     flags;
    } t_result;

endpackage

>>> rtl/usbsr_cfg_regs.sv
// Configuration register file of the USB standard request responder.
module usbsr_cfg_regs
    import usbsr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgAddrW-1:0] i_cfg_addr,
    input  logic [CfgDataW-1:0] i_cfg_data,
    output t_cfg                o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rwu_supported <= 1'b1;
            r_cfg.device_len    <= 8'd18;
            r_cfg.config_len    <= 8'd32;
            r_cfg.lang_len      <= 8'd4;
            r_cfg.manuf_len     <= 8'd16;
            r_cfg.product_len   <= 8'd16;
            r_cfg.iface_len     <= 8'd9;
            r_cfg.ep_len        <= 8'd7;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_addr))
                CFG_RWU_SUPPORTED: r_cfg.rwu_supported <= i_cfg_data[0];
                CFG_DEVICE_LEN:    r_cfg.device_len    <= i_cfg_data;
                CFG_CONFIG_LEN:    r_cfg.config_len    <= i_cfg_data;
                CFG_LANG_LEN:      r_cfg.lang_len      <= i_cfg_data;
                CFG_MANUF_LEN:     r_cfg.manuf_len     <= i_cfg_data;
                CFG_PRODUCT_LEN:   r_cfg.product_len   <= i_cfg_data;
                CFG_IFACE_LEN:     r_cfg.iface_len     <= i_cfg_data;
                CFG_EP_LEN:        r_cfg.ep_len        <= i_cfg_data;
                default:           r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/usbsr_decode.sv
// Event decoder: computes the result and the next device flags for one event.
module usbsr_decode
    import usbsr_pkg::*;
(
    input  logic [2:0] i_mode,
    input  t_setup     i_setup,
    input  t_flags     i_flags,
    input  t_cfg       i_cfg,
    output t_result    o_result,
    output t_flags     o_next_flags
);

    logic       send;
    logic [3:0] sel;
    logic [7:0] size;
    t_action    act;
    t_flags     nf;
    logic [7:0] idx_lo;
    logic [7:0] val_hi;
    logic [7:0] val_lo;
    logic       set_bit;

    assign idx_lo  = i_setup.req_index[7:0];
    assign val_hi  = i_setup.req_value[15:8];
    assign val_lo  = i_setup.req_value[7:0];
    assign set_bit = (i_setup.request_code == REQ_SET_FEATURE);

    always_comb begin
        send = 1'b0;
        sel  = SEL_DEV_STATUS;
        size = 8'd0;
        act  = ACT_NONE;
        nf   = i_flags;
        case (t_mode'(i_mode))
            MODE_SETUP: begin
                case (i_setup.request_code)
                    REQ_GET_STATUS: begin
                        act  = ACT_STALL;
                        size = STATUS_SIZE;
                        if (i_setup.request_type == RT_IN_DEVICE && idx_lo == 8'd0) begin
                            send = 1'b1;
                            sel  = i_flags.wakeup_on ? SEL_DEV_STATUS_WU : SEL_DEV_STATUS;
                        end else if (i_setup.request_type == RT_IN_IFACE
                                     && i_flags.configured && idx_lo == 8'd0) begin
                            send = 1'b1;
                            sel  = SEL_IFACE_STATUS;
                        end else if (i_setup.request_type == RT_IN_ENDPOINT) begin
                            if (idx_lo == 8'd0) begin
                                send = 1'b1;
                                sel  = SEL_EP_ACTIVE;
                            end else if (i_flags.configured && idx_lo == EP_IN1) begin
                                send = 1'b1;
                                sel  = i_flags.ep_halted ? SEL_EP_HALTED : SEL_EP_ACTIVE;
                            end
                        end
                    end
                    REQ_CLEAR_FEATURE, REQ_SET_FEATURE: begin
                        act = ACT_STALL;
                        if (i_setup.request_type == RT_OUT_ENDPOINT) begin
                            if (i_setup.req_value == FEAT_EP_HALT
                                && i_setup.req_index == {8'd0, EP_IN1}) begin
                                nf.ep_halted = set_bit;
                                act          = ACT_ACK;
                            end
                        end else if (i_setup.request_type == RT_OUT_DEVICE) begin
                            if (i_cfg.rwu_supported && i_setup.req_value == FEAT_REMOTE_WU) begin
                                nf.wakeup_on = set_bit;
                                act          = ACT_ACK;
                            end
                        end
                    end
                    REQ_SET_ADDRESS: begin
                        act = ACT_NONE;
                    end
                    REQ_GET_DESCRIPTOR: begin
                        act = ACT_STALL;
                        if (i_setup.request_type == RT_IN_DEVICE) begin
                            case (val_hi)
                                DESC_DEVICE: begin
                                    send = 1'b1;
                                    sel  = SEL_DEVICE_DESC;
                                    size = i_cfg.device_len;
                                end
                                DESC_CONFIG: begin
                                    send = 1'b1;
                                    sel  = SEL_CONFIG_DESC;
                                    size = i_cfg.config_len;
                                end
                                DESC_STRING: begin
                                    if (val_lo == 8'd0) begin
                                        send = 1'b1;
                                        sel  = SEL_LANG_STRING;
                                        size = i_cfg.lang_len;
                                    end else if (val_lo == 8'd1) begin
                                        send = 1'b1;
                                        sel  = SEL_MANUF_STRING;
                                        size = i_cfg.manuf_len;
                                    end else if (val_lo == 8'd2) begin
                                        send = 1'b1;
                                        sel  = SEL_PROD_STRING;
                                        size = i_cfg.product_len;
                                    end
                                end
                                DESC_IFACE: begin
                                    if (val_lo == 8'd0) begin
                                        send = 1'b1;
                                        sel  = SEL_IFACE_DESC;
                                        size = i_cfg.iface_len;
                                    end
                                end
                                DESC_ENDPOINT: begin
                                    if (val_lo == 8'd1) begin
                                        send = 1'b1;
                                        sel  = SEL_EP_DESC;
                                        size = i_cfg.ep_len;
                                    end
                                end
                                default: begin
                                    send = 1'b0;
                                end
                            endcase
                        end
                    end
                    REQ_GET_CONFIG: begin
                        send = 1'b1;
                        sel  = i_flags.configured ? SEL_CONFIG_CONF : SEL_CONFIG_UNCONF;
                        size = CONFIG_SIZE;
                    end
                    REQ_SET_CONFIG: begin
                        act = ACT_STALL;
                        if (i_setup.request_type == RT_OUT_DEVICE
                            && i_setup.req_index == 16'd0
                            && i_setup.req_length == 16'd0) begin
                            if (i_setup.req_value == CONFIG_ONE) begin
                                nf.ep_halted  = 1'b0;
                                nf.configured = 1'b1;
                                act           = ACT_ACK;
                            end else if (i_setup.req_value == CONFIG_NONE) begin
                                nf.configured = 1'b0;
                                act           = ACT_ACK;
                            end
                        end
                    end
                    default: begin
                        act = ACT_STALL;
                    end
                endcase
            end
            MODE_BUS_RESET: begin
                nf.configured = 1'b0;
                nf.suspend    = 1'b0;
                act           = ACT_ACK;
            end
            MODE_SUSPEND: begin
                nf.suspend = 1'b1;
            end
            MODE_RESUME: begin
                nf.suspend = 1'b0;
            end
            MODE_EP0_DONE: begin
                case (t_xfer_status'(i_setup.transfer_status))
                    XFER_OK:      act = ACT_ACK;
                    XFER_ABORTED: act = ACT_NONE;
                    default:      act = ACT_STALL;
                endcase
            end
            MODE_POWER_OFF: begin
                nf.configured = 1'b0;
            end
            default: begin
                act = ACT_NONE;
            end
        endcase
    end

    always_comb begin
        o_result.action          = act;
        o_result.response_select = SEL_DEV_STATUS;
        o_result.send_length     = 8'd0;
        o_result.flags           = nf;
        if (send) begin
            o_result.action          = ACT_SEND;
            o_result.response_select = sel;
            o_result.send_length     = (i_setup.req_length < {8'd0, size})
                                       ? i_setup.req_length[7:0] : size;
        end
    end

    assign o_next_flags = nf;

endmodule

>>> rtl/usb_standard_request_responder.sv
// Top level of the USB standard request responder: input stage, decoder, result stage.
//
// Each beat on the slave stream is one device event: tuser carries the event
// mode and tdata carries the setup fields and the EP0 transfer status. Each
// event yields exactly one result beat on the master stream: tuser carries the
// action and tdata carries the response selection, the clipped send length and
// the four device flags as they stand after the event.
// An accepted event is held in an input register, decoded combinationally
// and stored in a result register, which presents the result beat. One
// event per cycle is sustained while the receiver keeps m_axis_tready high;
// the device flags are updated as an event moves into the result register,
// so the next event is decoded against them without a bubble.
// When the receiver stalls, the result register holds its beat and the input
// register keeps one more event; s_axis_tready falls only once both are full.
// The configuration port writes one register per cycle on i_cfg_we and
// should be used while no event is in flight.
// Reset clears both stages, all four flags and restores the register defaults.
module usb_standard_request_responder
    import usbsr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // Fields from bit 0: request_type, request_code, req_value, req_index,
    // req_length, transfer_status, zero fill.
    input  logic [TdataInW-1:0]  s_axis_tdata,
    // Fields from bit 0: mode.
    input  logic [TuserInW-1:0]  s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // Fields from bit 0: response_select, send_length, configured_flag,
    // wakeup_enabled, in_ep_halted, suspend_requested.
    output logic [TdataOutW-1:0] m_axis_tdata,
    // Fields from bit 0: action.
    output logic [TuserOutW-1:0] m_axis_tuser,
    input  logic                 i_cfg_we,
    input  logic [CfgAddrW-1:0]  i_cfg_addr,
    input  logic [CfgDataW-1:0]  i_cfg_data
);

    logic       r_in_valid;
    logic [2:0] r_in_mode;
    t_setup     r_in_setup;
    logic       r_out_valid;
    t_result    r_out;
    t_flags     r_flags;

    t_cfg       cfg;
    t_result    dec_result;
    t_flags     n_flags;
    logic       advance;
    logic       in_take;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    usbsr_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    usbsr_decode u_decode (
        .i_mode       (r_in_mode),
        .i_setup      (r_in_setup),
        .i_flags      (r_flags),
        .i_cfg        (cfg),
        .o_result     (dec_result),
        .o_next_flags (n_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_flags     <= n_flags;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_mode  <= s_axis_tuser;
            r_in_setup <= t_setup'(s_axis_tdata[$bits(t_setup)-1:0]);
        end
        if (advance) begin
            r_out <= dec_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.action;
    assign m_axis_tdata  = {r_out.flags.suspend, r_out.flags.ep_halted,
                            r_out.flags.wakeup_on, r_out.flags.configured,
                            r_out.send_length, r_out.response_select};

`ifndef ASSERT_OFF
    a_nodata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.action != ACT_SEND)
        |-> (r_out.response_select == SEL_DEV_STATUS && r_out.send_length == 8'd0))
        else $error("result without data carries a selection or length");

    a_len_clipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> ({8'd0, r_out.send_length} <= $past(r_in_setup.req_length)))
        else $error("send length exceeds requested length");

    a_bus_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_mode == MODE_BUS_RESET)
        |=> (r_out.action == ACT_ACK && !r_flags.configured && !r_flags.suspend))
        else $error("bus reset did not acknowledge and clear flags");

    a_flags_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.flags.configured == r_flags.configured || r_in_valid))
        else $error("reported configured flag out of step with state");
`endif

endmodule

>>> tb/sv/usb_standard_request_responder_tb.sv
// Self-checking testbench for the USB standard request responder: directed and random device events under several register settings.
module usb_standard_request_responder_tb;
    import usbsr_pkg::*;

    localparam int NUM_SETTINGS       = 7;
    localparam int RANDOM_PER_SETTING = 275;
    localparam int TIMEOUT_CYCLES     = 500000;
    localparam int HOLD_CYCLES        = 150;

    localparam logic [2:0] MODE_UNUSED_LO = 3'd6;
    localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
    localparam logic [1:0] XFER_UNDEFINED = 2'd3;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  rtype;
        logic [7:0]  code;
        logic [15:0] value;
        logic [15:0] index;
        logic [15:0] length;
        logic [1:0]  status;
    } t_event;

    typedef struct packed {
        t_action    act;
        logic [3:0] sel;
        logic [7:0] len;
        logic       configured;
        logic       wakeup;
        logic       halted;
        logic       suspend;
    } t_reply;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [TdataInW-1:0]  s_axis_tdata  = '0;
    logic [TuserInW-1:0]  s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [TdataOutW-1:0] m_axis_tdata;
    logic [TuserOutW-1:0] m_axis_tuser;
    logic                 i_cfg_we      = 1'b0;
    logic [CfgAddrW-1:0]  i_cfg_addr    = '0;
    logic [CfgDataW-1:0]  i_cfg_data    = '0;

    // Device state and register copies as the checker sees them.
    logic       cfg_rwu        = 1'b1;
    logic [7:0] desc_size [1:7];
    logic       dev_configured = 1'b0;
    logic       dev_wakeup     = 1'b0;
    logic       ep1_halted     = 1'b0;
    logic       suspend_flag   = 1'b0;

    t_event pending_events [$];
    t_reply predicted_replies [$];
    t_event offered     = '0;
    t_reply want_reply  = '0;
    int     src_wait    = 0;
    bit     src_calm    = 1'b0;
    int     rcv_wait    = 0;
    bit     rcv_calm    = 1'b0;
    int     hold_left   = 0;
    int     holds_done  = 0;
    int     n_issued    = 0;
    int     n_accepted  = 0;
    int     n_results   = 0;
    int     n_errors    = 0;
    int     action_count [4] = '{0, 0, 0, 0};

    usb_standard_request_responder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_reply data_reply(logic [3:0] sel, logic [7:0] full, logic [15:0] wlen);
        t_reply r;
        r     = '0;
        r.act = ACT_SEND;
        r.sel = sel;
        r.len = (wlen < {8'h00, full}) ? wlen[7:0] : full;
        return r;
    endfunction

    function automatic t_reply respond_to_event(t_event ev);
        t_reply r;
        logic   setting;
        r = '0;
        case (ev.mode)
            MODE_SETUP: begin
                r.act = ACT_STALL;
                case (ev.code)
                    REQ_GET_STATUS: begin
                        if (ev.rtype == RT_IN_DEVICE && ev.index[7:0] == 8'h00) begin
                            r = data_reply(dev_wakeup ? SEL_DEV_STATUS_WU : SEL_DEV_STATUS,
                                           STATUS_SIZE, ev.length);
                        end else if (ev.rtype == RT_IN_IFACE && dev_configured
                                     && ev.index[7:0] == 8'h00) begin
                            r = data_reply(SEL_IFACE_STATUS, STATUS_SIZE, ev.length);
                        end else if (ev.rtype == RT_IN_ENDPOINT && ev.index[7:0] == 8'h00) begin
                            r = data_reply(SEL_EP_ACTIVE, STATUS_SIZE, ev.length);
                        end else if (ev.rtype == RT_IN_ENDPOINT && dev_configured
                                     && ev.index[7:0] == EP_IN1) begin
                            r = data_reply(ep1_halted ? SEL_EP_HALTED : SEL_EP_ACTIVE,
                                           STATUS_SIZE, ev.length);
                        end
                    end
                    REQ_CLEAR_FEATURE, REQ_SET_FEATURE: begin
                        setting = (ev.code == REQ_SET_FEATURE);
                        if (ev.rtype == RT_OUT_ENDPOINT && ev.value == FEAT_EP_HALT
                            && ev.index == {8'h00, EP_IN1}) begin
                            ep1_halted = setting;
                            r.act      = ACT_ACK;
                        end else if (ev.rtype == RT_OUT_DEVICE && cfg_rwu
                                     && ev.value == FEAT_REMOTE_WU) begin
                            dev_wakeup = setting;
                            r.act      = ACT_ACK;
                        end
                    end
                    REQ_SET_ADDRESS: r.act = ACT_NONE;
                    REQ_GET_DESCRIPTOR: begin
                        if (ev.rtype == RT_IN_DEVICE) begin
                            case (ev.value[15:8])
                                DESC_DEVICE: begin
                                    r = data_reply(SEL_DEVICE_DESC, desc_size[CFG_DEVICE_LEN],
                                                   ev.length);
                                end
                                DESC_CONFIG: begin
                                    r = data_reply(SEL_CONFIG_DESC, desc_size[CFG_CONFIG_LEN],
                                                   ev.length);
                                end
                                DESC_STRING: begin
                                    if (ev.value[7:0] == 8'd0) begin
                                        r = data_reply(SEL_LANG_STRING, desc_size[CFG_LANG_LEN],
                                                       ev.length);
                                    end else if (ev.value[7:0] == 8'd1) begin
                                        r = data_reply(SEL_MANUF_STRING, desc_size[CFG_MANUF_LEN],
                                                       ev.length);
                                    end else if (ev.value[7:0] == 8'd2) begin
                                        r = data_reply(SEL_PROD_STRING, desc_size[CFG_PRODUCT_LEN],
                                                       ev.length);
                                    end
                                end
                                DESC_IFACE: begin
                                    if (ev.value[7:0] == 8'd0) begin
                                        r = data_reply(SEL_IFACE_DESC, desc_size[CFG_IFACE_LEN],
                                                       ev.length);
                                    end
                                end
                                DESC_ENDPOINT: begin
                                    if (ev.value[7:0] == 8'd1) begin
                                        r = data_reply(SEL_EP_DESC, desc_size[CFG_EP_LEN],
                                                       ev.length);
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                    REQ_GET_CONFIG: begin
                        r = data_reply(dev_configured ? SEL_CONFIG_CONF : SEL_CONFIG_UNCONF,
                                       CONFIG_SIZE, ev.length);
                    end
                    REQ_SET_CONFIG: begin
                        if (ev.rtype == RT_OUT_DEVICE && ev.index == 16'h0000
                            && ev.length == 16'h0000) begin
                            if (ev.value == CONFIG_ONE) begin
                                ep1_halted     = 1'b0;
                                dev_configured = 1'b1;
                                r.act          = ACT_ACK;
                            end else if (ev.value == CONFIG_NONE) begin
                                dev_configured = 1'b0;
                                r.act          = ACT_ACK;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            MODE_BUS_RESET: begin
                dev_configured = 1'b0;
                suspend_flag   = 1'b0;
                r.act          = ACT_ACK;
            end
            MODE_SUSPEND: suspend_flag = 1'b1;
            MODE_RESUME: suspend_flag = 1'b0;
            MODE_EP0_DONE: begin
                if (ev.status == XFER_OK) begin
                    r.act = ACT_ACK;
                end else if (ev.status == XFER_ABORTED) begin
                    r.act = ACT_NONE;
                end else begin
                    r.act = ACT_STALL;
                end
            end
            MODE_POWER_OFF: dev_configured = 1'b0;
            default: ;
        endcase
        r.configured = dev_configured;
        r.wakeup     = dev_wakeup;
        r.halted     = ep1_halted;
        r.suspend    = suspend_flag;
        return r;
    endfunction

    function automatic t_event setup_event(logic [7:0] rtype, logic [7:0] code,
                                           logic [15:0] value, logic [15:0] index,
                                           logic [15:0] length);
        t_event ev;
        ev        = '0;
        ev.mode   = MODE_SETUP;
        ev.rtype  = rtype;
        ev.code   = code;
        ev.value  = value;
        ev.index  = index;
        ev.length = length;
        return ev;
    endfunction

    function automatic t_event bus_event(logic [2:0] mode, logic [1:0] status);
        t_event ev;
        ev        = '0;
        ev.mode   = mode;
        ev.status = status;
        return ev;
    endfunction

    function automatic t_event random_event();
        t_event ev;
        int     pick;
        ev.mode   = 3'($urandom_range(0, 7));
        ev.rtype  = 8'($urandom);
        ev.code   = 8'($urandom);
        ev.value  = 16'($urandom);
        ev.index  = 16'($urandom);
        ev.length = 16'($urandom);
        ev.status = 2'($urandom);
        pick = $urandom_range(0, 99);
        if (pick >= 88) begin
            return ev;
        end
        if (pick >= 70) begin
            ev.mode = 3'($urandom_range(1, 5));
            return ev;
        end
        ev.mode = MODE_SETUP;
        case ($urandom_range(0, 6))
            0: ev.code = REQ_GET_STATUS;
            1: ev.code = REQ_CLEAR_FEATURE;
            2: ev.code = REQ_SET_FEATURE;
            3: ev.code = REQ_SET_ADDRESS;
            4: ev.code = REQ_GET_DESCRIPTOR;
            5: ev.code = REQ_GET_CONFIG;
            default: ev.code = REQ_SET_CONFIG;
        endcase
        case ($urandom_range(0, 3))
            0: ev.length = 16'h0000;
            1: ev.length = 16'($urandom_range(0, 40));
            2: ev.length = 16'($urandom_range(0, 300));
            default: ;
        endcase
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 5))
                0: ev.rtype = RT_OUT_DEVICE;
                1: ev.rtype = RT_OUT_ENDPOINT;
                2: ev.rtype = RT_IN_DEVICE;
                3: ev.rtype = RT_IN_IFACE;
                4: ev.rtype = RT_IN_ENDPOINT;
                default: ;
            endcase
            case ($urandom_range(0, 2))
                0: ev.value = 16'($urandom_range(0, 2));
                1: ev.value = {8'($urandom_range(0, 6)), 8'($urandom_range(0, 3))};
                default: ;
            endcase
            case ($urandom_range(0, 2))
                0: ev.index = 16'h0000;
                1: ev.index = {8'h00, EP_IN1};
                default: ;
            endcase
            return ev;
        end
        case (ev.code)
            REQ_GET_STATUS: begin
                case ($urandom_range(0, 2))
                    0: ev.rtype = RT_IN_DEVICE;
                    1: ev.rtype = RT_IN_IFACE;
                    default: ev.rtype = RT_IN_ENDPOINT;
                endcase
                ev.index[7:0] = $urandom_range(0, 1) ? EP_IN1 : 8'h00;
                if ($urandom_range(0, 1)) ev.index[15:8] = 8'h00;
            end
            REQ_CLEAR_FEATURE, REQ_SET_FEATURE: begin
                if ($urandom_range(0, 1)) begin
                    ev.rtype = RT_OUT_ENDPOINT;
                    ev.value = FEAT_EP_HALT;
                    ev.index = {8'h00, EP_IN1};
                end else begin
                    ev.rtype = RT_OUT_DEVICE;
                    ev.value = FEAT_REMOTE_WU;
                    ev.index = 16'h0000;
                end
            end
            REQ_GET_DESCRIPTOR: begin
                ev.rtype = RT_IN_DEVICE;
                ev.value = {8'($urandom_range(DESC_DEVICE, DESC_ENDPOINT)),
                            8'($urandom_range(0, 2))};
            end
            REQ_SET_CONFIG: begin
                ev.rtype  = RT_OUT_DEVICE;
                ev.index  = 16'h0000;
                ev.length = 16'h0000;
                ev.value  = 16'($urandom_range(0, 2));
            end
            default: ;
        endcase
        return ev;
    endfunction

    task automatic queue_event(t_event ev);
        pending_events.push_back(ev);
        n_issued++;
    endtask

    task automatic write_reg(t_cfg_index which, logic [7:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= which;
        i_cfg_data <= data;
        if (which == CFG_RWU_SUPPORTED) begin
            cfg_rwu = data[0];
        end else begin
            desc_size[which] = data;
        end
    endtask

    task automatic drain_replies();
        while (n_results < n_issued) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic compare_field(string what, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_wait = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predicted_replies.push_back(respond_to_event(offered));
                n_accepted <= n_accepted + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_wait > 0) begin
                    src_wait--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_events.size() > 0) begin
                    offered = pending_events.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= offered.mode;
                    s_axis_tdata  <= {{(TdataInW - 66){1'b0}}, offered.status, offered.length,
                                      offered.index, offered.value, offered.code, offered.rtype};
                    if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
                    src_wait = src_calm ? 0 : $urandom_range(0, 9);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // The receiver holds off for a long stretch a few times so that both stages fill.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left  <= 0;
            holds_done <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_done < 3 && n_accepted >= 400 + 600 * holds_done) begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rcv_wait = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_results <= n_results + 1;
                if (predicted_replies.size() == 0) begin
                    $display("%0t: result beat with nothing expected, actual tuser %0d tdata %h",
                             $time, m_axis_tuser, m_axis_tdata);
                    n_errors++;
                end else begin
                    want_reply = predicted_replies.pop_front();
                    action_count[m_axis_tuser]++;
                    compare_field("action", 8'(want_reply.act), 8'(m_axis_tuser));
                    compare_field("response_select", 8'(want_reply.sel),
                                  8'(m_axis_tdata[3:0]));
                    compare_field("send_length", want_reply.len, m_axis_tdata[11:4]);
                    compare_field("configured_flag", 8'(want_reply.configured),
                                  8'(m_axis_tdata[12]));
                    compare_field("wakeup_enabled", 8'(want_reply.wakeup),
                                  8'(m_axis_tdata[13]));
                    compare_field("in_ep_halted", 8'(want_reply.halted),
                                  8'(m_axis_tdata[14]));
                    compare_field("suspend_requested", 8'(want_reply.suspend),
                                  8'(m_axis_tdata[15]));
                end
            end
            if (hold_left != 0) begin
                m_axis_tready <= 1'b0;
            end else if (m_axis_tvalid && m_axis_tready) begin
                if ($urandom_range(0, 29) == 0) rcv_calm = !rcv_calm;
                rcv_wait = rcv_calm ? 0 : $urandom_range(0, 9);
                if (rcv_wait != 0) m_axis_tready <= 1'b0;
            end else if (!m_axis_tready) begin
                if (rcv_wait > 1) begin
                    rcv_wait--;
                end else begin
                    rcv_wait = 0;
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    initial begin : stimulus
        int         ph;
        int         k;
        logic [7:0] reg_value;
        desc_size[CFG_DEVICE_LEN]  = 8'd18;
        desc_size[CFG_CONFIG_LEN]  = 8'd32;
        desc_size[CFG_LANG_LEN]    = 8'd4;
        desc_size[CFG_MANUF_LEN]   = 8'd16;
        desc_size[CFG_PRODUCT_LEN] = 8'd16;
        desc_size[CFG_IFACE_LEN]   = 8'd9;
        desc_size[CFG_EP_LEN]      = 8'd7;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (ph = 0; ph < NUM_SETTINGS; ph++) begin
            if (ph == 0) begin
                queue_event(setup_event(RT_IN_DEVICE, REQ_GET_STATUS, 16'h0000, 16'h0000,
                                        16'hFFFF));
                queue_event(setup_event(RT_OUT_DEVICE, REQ_SET_FEATURE, FEAT_REMOTE_WU,
                                        16'h0000, 16'h0000));
                queue_event(setup_event(RT_IN_DEVICE, REQ_GET_STATUS, 16'h0000, 16'hFF00,
                                        16'h0001));
                queue_event(setup_event(RT_IN_IFACE, REQ_GET_STATUS, 16'h0000, 16'h0000,
                                        16'h0002));
                queue_event(setup_event(RT_OUT_DEVICE, REQ_SET_CONFIG, CONFIG_ONE, 16'h0000,
                                        16'h0000));
                queue_event(setup_event(RT_IN_IFACE, REQ_GET_STATUS, 16'h0000, 16'h0000,
                                        16'h0000));
                queue_event(setup_event(RT_OUT_ENDPOINT, REQ_SET_FEATURE, FEAT_EP_HALT,
                                        {8'h00, EP_IN1}, 16'h0000));
                queue_event(setup_event(RT_IN_ENDPOINT, REQ_GET_STATUS, 16'h0000,
                                        {8'hFF, EP_IN1}, 16'hFFFF));
                queue_event(setup_event(RT_OUT_ENDPOINT, REQ_CLEAR_FEATURE, FEAT_EP_HALT,
                                        {8'h00, EP_IN1}, 16'h0000));
                queue_event(setup_event(8'hFF, REQ_GET_CONFIG, 16'hFFFF, 16'hFFFF, 16'hFFFF));
                queue_event(setup_event(RT_OUT_DEVICE, REQ_SET_ADDRESS, 16'h007F, 16'h0000,
                                        16'h0000));
                queue_event(setup_event(RT_IN_DEVICE, REQ_GET_DESCRIPTOR, {DESC_DEVICE, 8'h00},
                                        16'h0000, 16'hFFFF));
                queue_event(setup_event(RT_IN_DEVICE, REQ_GET_DESCRIPTOR, {DESC_CONFIG, 8'h00},
                                        16'h0000, 16'h0009));
                for (k = 0; k < 4; k++) begin
                    queue_event(setup_event(RT_IN_DEVICE, REQ_GET_DESCRIPTOR,
                                            {DESC_STRING, 8'(k)}, 16'h0409,
                                            (k == 2) ? 16'h0000 : 16'h00FF));
                end
                queue_event(setup_event(RT_IN_DEVICE, REQ_GET_DESCRIPTOR, {DESC_IFACE, 8'h00},
                                        16'h0000, 16'h0040));
                queue_event(setup_event(RT_IN_DEVICE, REQ_GET_DESCRIPTOR,
                                        {DESC_ENDPOINT, 8'h01}, 16'h0000, 16'h0040));
                queue_event(setup_event(RT_OUT_DEVICE, REQ_SET_CONFIG, CONFIG_ONE, 16'h0000,
                                        16'h0001));
                queue_event(setup_event(RT_OUT_DEVICE, REQ_SET_CONFIG, 16'h0002, 16'h0000,
                                        16'h0000));
                queue_event(setup_event(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
                queue_event(bus_event(MODE_SUSPEND, XFER_OK));
                queue_event(bus_event(MODE_BUS_RESET, XFER_OK));
                queue_event(bus_event(MODE_SUSPEND, XFER_OK));
                queue_event(bus_event(MODE_RESUME, XFER_OK));
                for (k = 0; k < 4; k++) queue_event(bus_event(MODE_EP0_DONE, 2'(k)));
                queue_event(setup_event(RT_OUT_DEVICE, REQ_SET_CONFIG, CONFIG_ONE, 16'h0000,
                                        16'h0000));
                queue_event(bus_event(MODE_POWER_OFF, XFER_UNDEFINED));
                queue_event(bus_event(MODE_UNUSED_LO, XFER_UNDEFINED));
                queue_event(bus_event(MODE_UNUSED_HI, XFER_OK));
            end else begin
                drain_replies();
                if (ph == 1) begin
                    write_reg(CFG_RWU_SUPPORTED, 8'd0);
                end else if (ph == 2) begin
                    write_reg(CFG_RWU_SUPPORTED, 8'd1);
                end else begin
                    write_reg(CFG_RWU_SUPPORTED, 8'($urandom_range(0, 1)));
                end
                for (k = 1; k < 8; k++) begin
                    if (ph == 1) begin
                        reg_value = 8'd0;
                    end else if (ph == 2) begin
                        reg_value = 8'd255;
                    end else if ($urandom_range(0, 3) == 0) begin
                        reg_value = 8'($urandom_range(0, 255));
                    end else begin
                        reg_value = 8'($urandom_range(0, 40));
                    end
                    write_reg(t_cfg_index'(k), reg_value);
                end
                @(posedge i_clk);
                i_cfg_we <= 1'b0;
            end
            repeat (RANDOM_PER_SETTING) queue_event(random_event());
        end
        drain_replies();
        repeat (8) @(posedge i_clk);
        if (predicted_replies.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, predicted_replies.size());
            n_errors++;
        end
        $display("Sent %0d device events across %0d register settings, checked %0d result beats.",
                 n_issued, NUM_SETTINGS, n_results);
        $display("Actions returned: none %0d, acknowledge %0d, stall %0d, send %0d.",
                 action_count[ACT_NONE], action_count[ACT_ACK], action_count[ACT_STALL],
                 action_count[ACT_SEND]);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #(12 * TIMEOUT_CYCLES);
        $display("Timeout after %0d cycles with %0d of %0d results received.",
                 TIMEOUT_CYCLES, n_results, n_issued);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
rtl/usbsr_pkg.sv
rtl/usbsr_cfg_regs.sv
rtl/usbsr_decode.sv
rtl/usb_standard_request_responder.sv
tb/sv/usb_standard_request_responder_tb.sv
